// ===== hdl/sas_pkg.sv =====
// Shared types, widths and constants of the sprite animation stepper.
// No dependencies; every other file refers to it by scoped names.
package sas_pkg;

    // Field widths
    localparam int FC_W       = 8;
    localparam int MS_W       = 16;
    localparam int MODE_W     = 6;
    localparam int LEVEL_W    = 16;
    localparam int ANGLE_W    = 32;
    localparam int START_W    = 16;
    localparam int TURN_W     = 16;
    localparam int ACC_W      = 32;
    localparam int FRAME_O_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Finish angle ranges held in the finish_ranges register
    localparam int NUM_FINISH_RANGES = 2;
    localparam int RANGE_STRIDE      = 32;
    localparam int RANGE_W           = 16;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT   = 3'd0,
        CFG_FRAME_PERIOD  = 3'd1,
        CFG_MODE_FLAGS    = 3'd2,
        CFG_FADE_RATE     = 3'd3,
        CFG_FADE_LEVELS   = 3'd4,
        CFG_SPIN_RATE     = 3'd5,
        CFG_MIN_TURNS     = 3'd6,
        CFG_FINISH_RANGES = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_TICK  = 1'b1
    } t_func;

    // mode_flags bit positions
    localparam int MODE_FRAME_LOOP  = 0;
    localparam int MODE_FADE_EN     = 1;
    localparam int MODE_FADE_LOOP   = 2;
    localparam int MODE_ROT_EN      = 3;
    localparam int MODE_ROT_LOOP    = 4;
    localparam int MODE_GLOBAL_LOOP = 5;

    // One full turn in 1/64 degree
    localparam int TURN_UNITS = 23040;

    // x / 1000 = (x * RECIP_1000) >> 41, exact for any 32-bit x
    localparam int             DIV_W        = 23;
    localparam logic [31:0]    RECIP_1000   = 32'd2199023256;
    localparam int             RECIP_1000_SH = 41;

    // x / 23040 = ((x >> 9) / 45); /45 by reciprocal
    localparam int             TURN_SHIFT     = 9;
    localparam logic [22:0]    RECIP_45_T     = 23'd5965233;
    localparam int             RECIP_45_T_SH  = 28;
    localparam logic [23:0]    RECIP_45_M     = 24'd11930465;
    localparam int             RECIP_45_M_SH  = 29;
    localparam int             QM_W           = 18;
    localparam int             REM_W          = 15;
    // Smallest angle difference that gives 65536 turns
    localparam logic [32:0]    TURN_CLAMP     = 33'd1509949440;

    typedef struct packed {
        logic [FC_W-1:0]       frame_count;
        logic [MS_W-1:0]       frame_period_ms;
        logic [MODE_W-1:0]     mode_flags;
        logic [MS_W-1:0]       fade_rate;
        logic [31:0]           fade_levels;
        logic [MS_W-1:0]       spin_rate;
        logic [TURN_W-1:0]     min_turns;
        logic [CFG_DATA_W-1:0] finish_ranges;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        frame_count:     8'd1,
        frame_period_ms: 16'd100,
        mode_flags:      '0,
        fade_rate:       '0,
        fade_levels:     '0,
        spin_rate:       '0,
        min_turns:       '0,
        finish_ranges:   '0
    };

    // Status of one item as it enters the finish test
    typedef struct packed {
        logic [ACC_W-1:0]   accum;
        logic [LEVEL_W-1:0] vis;
        logic [TURN_W-1:0]  turns;
        logic [ANGLE_W-1:0] aabs;
        logic [QM_W-1:0]    qm;
    } t_fin_in;

endpackage

// ===== hdl/sas_ifs.sv =====
// Channel interfaces of the sprite animation stepper: request, result, configuration.
// Depends on sas_pkg for field widths.
interface sas_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [sas_pkg::MS_W-1:0]            dt_ms;
    logic [sas_pkg::MS_W-1:0]            real_dt_ms;
    logic signed [sas_pkg::START_W-1:0]  start_angle;

    modport source (output valid, func, dt_ms, real_dt_ms, start_angle, input ready);
    modport sink   (input valid, func, dt_ms, real_dt_ms, start_angle, output ready);
endinterface

interface sas_out_if;
    logic                                valid;
    logic                                ready;
    logic [sas_pkg::FRAME_O_W-1:0]       frame_index;
    logic [sas_pkg::LEVEL_W-1:0]         visibility;
    logic signed [sas_pkg::ANGLE_W-1:0]  angle;
    logic [sas_pkg::TURN_W-1:0]          turns;
    logic                                finished;

    modport source (output valid, frame_index, visibility, angle, turns, finished,
                    input ready);
    modport sink   (input valid, frame_index, visibility, angle, turns, finished,
                    output ready);
endinterface

interface sas_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sas_pkg::CFG_IDX_W-1:0]    index;
    logic [sas_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sas_finish.sv =====
// Finish test of the sprite animation stepper: angle remainder, range match, loop, fade and frame checks.
// Depends on sas_pkg (t_cfg, t_fin_in, constants).
module sas_finish #(
    parameter int FRAME_BITS = 8
) (
    input  sas_pkg::t_cfg            i_cfg,
    input  logic [FRAME_BITS-1:0]    i_frame,
    input  sas_pkg::t_fin_in         i_st,
    output logic                     o_finished
);

    localparam int CW = ((FRAME_BITS > sas_pkg::FC_W) ? FRAME_BITS : sas_pkg::FC_W) + 1;

    logic [sas_pkg::ANGLE_W-1:0] w_rem_full;
    logic [sas_pkg::REM_W-1:0]   w_rem;
    logic                        w_hit;
    logic                        w_loop_any;
    logic                        w_fade_ok;
    logic                        w_rot_ok;
    logic                        w_frame_ok;

    // qm is the registered quotient, so this is only a constant scale and subtract
    assign w_rem_full = i_st.aabs
                      - (32'(i_st.qm) * 32'(sas_pkg::TURN_UNITS));
    assign w_rem      = w_rem_full[sas_pkg::REM_W-1:0];

    always_comb begin
        w_hit = 1'b0;
        for (int k = 0; k < sas_pkg::NUM_FINISH_RANGES; k++) begin
            if ((16'(w_rem) >= i_cfg.finish_ranges[sas_pkg::RANGE_STRIDE*k +: sas_pkg::RANGE_W])
                && (16'(w_rem) <= i_cfg.finish_ranges[sas_pkg::RANGE_STRIDE*k
                                   + sas_pkg::RANGE_W +: sas_pkg::RANGE_W])) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_loop_any = i_cfg.mode_flags[sas_pkg::MODE_FRAME_LOOP]
                      | i_cfg.mode_flags[sas_pkg::MODE_FADE_LOOP]
                      | i_cfg.mode_flags[sas_pkg::MODE_ROT_LOOP]
                      | i_cfg.mode_flags[sas_pkg::MODE_GLOBAL_LOOP];

    assign w_fade_ok = !i_cfg.mode_flags[sas_pkg::MODE_FADE_EN]
                     || (i_st.vis <= i_cfg.fade_levels[sas_pkg::LEVEL_W-1:0]);

    assign w_rot_ok  = !i_cfg.mode_flags[sas_pkg::MODE_ROT_EN]
                     || ((i_st.turns > i_cfg.min_turns) && w_hit);

    always_comb begin
        if (i_cfg.frame_count == 8'd1) begin
            w_frame_ok = (i_st.accum >= 32'(i_cfg.frame_period_ms));
        end else if (i_cfg.frame_count == 8'd0) begin
            w_frame_ok = 1'b1;
        end else begin
            w_frame_ok = (CW'(i_frame) >= (CW'(i_cfg.frame_count) - CW'(1)));
        end
    end

    assign o_finished = !w_loop_any && w_fade_ok && w_rot_ok && w_frame_ok;

endmodule

// ===== hdl/sprite_animation_stepper_core.sv =====
// Top level of the sprite animation stepper: config registers, six-stage pipeline.
// Depends on sas_pkg, the channel interfaces in sas_ifs.sv and sas_finish.
//
// Usage
//   i_cfg : register writes (index 0..7, data in the low bits). Always ready;
//           write only while no request is in flight.
//   i_req : one request per valid/ready handshake. func = start rewinds the
//           animation (frame 0, accumulator 0, visibility at the fade start
//           level, angle at start_angle); func = tick advances time.
//   o_res : one result per request, in order: frame, visibility, angle,
//           turns and the finished flag after that request.
// Timing
//   A request passes through stage registers 0 to 5 before its result shows
//   on o_res. One request per cycle is taken sustained while o_res is ready;
//   the state update (frame, accumulator, visibility, angle) is a loop on
//   the stage 3 registers, and the divides by 1000 and by one turn are
//   reciprocal multiplies in their own stages on either side of it.
// Reset
//   Synchronous, active low: config registers return to their reset values, the
//   animation state clears to zero and the pipeline empties.
// Back-pressure
//   Each full stage holds while the next one cannot move; a stalled o_res still
//   lets requests in until the bubbles ahead of it are used up.
module sprite_animation_stepper_core #(
    parameter int FRAME_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sas_cfg_if.sink       i_cfg,
    sas_in_if.sink        i_req,
    sas_out_if.source     o_res
);

    localparam int NSTG = 6;
    localparam int CW   = ((FRAME_BITS > sas_pkg::FC_W) ? FRAME_BITS : sas_pkg::FC_W) + 1;
    localparam int VW   = sas_pkg::DIV_W + 1;   // signed width for visibility / delta maths

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    sas_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sas_pkg::CFG_RST;
        end else if (i_cfg.valid) begin
            case (sas_pkg::t_cfg_idx'(i_cfg.index))
                sas_pkg::CFG_FRAME_COUNT:   r_cfg.frame_count     <= i_cfg.data[7:0];
                sas_pkg::CFG_FRAME_PERIOD:  r_cfg.frame_period_ms <= i_cfg.data[15:0];
                sas_pkg::CFG_MODE_FLAGS:    r_cfg.mode_flags      <= i_cfg.data[5:0];
                sas_pkg::CFG_FADE_RATE:     r_cfg.fade_rate       <= i_cfg.data[15:0];
                sas_pkg::CFG_FADE_LEVELS:   r_cfg.fade_levels     <= i_cfg.data[31:0];
                sas_pkg::CFG_SPIN_RATE:     r_cfg.spin_rate       <= i_cfg.data[15:0];
                sas_pkg::CFG_MIN_TURNS:     r_cfg.min_turns       <= i_cfg.data[15:0];
                sas_pkg::CFG_FINISH_RANGES: r_cfg.finish_ranges   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage moves when empty or when the next moves
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int k = NSTG-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_req.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: request register
    // ------------------------------------------------------------------
    sas_pkg::t_func                      r_s0_func;
    logic [sas_pkg::MS_W-1:0]            r_s0_dt;
    logic [sas_pkg::MS_W-1:0]            r_s0_rdt;
    logic [sas_pkg::START_W-1:0]         r_s0_start;

    always_ff @(posedge i_clk) begin
        if (en[0] && i_req.valid) begin
            r_s0_func  <= sas_pkg::t_func'(i_req.func);
            r_s0_dt    <= i_req.dt_ms;
            r_s0_rdt   <= i_req.real_dt_ms;
            r_s0_start <= i_req.start_angle;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: rate products (spin handled as sign and magnitude)
    // ------------------------------------------------------------------
    logic [sas_pkg::MS_W-1:0] w_spin_mag;
    sas_pkg::t_func           r_s1_func;
    logic [sas_pkg::MS_W-1:0] r_s1_dt;
    logic [sas_pkg::START_W-1:0] r_s1_start;
    logic [31:0]              r_fprod;
    logic [31:0]              r_sprod;
    logic                     r_s1_sneg;

    assign w_spin_mag = r_cfg.spin_rate[sas_pkg::MS_W-1] ? (~r_cfg.spin_rate + 16'd1)
                                                          : r_cfg.spin_rate;

    always_ff @(posedge i_clk) begin
        if (en[1] && r_vld[0]) begin
            r_s1_func  <= r_s0_func;
            r_s1_dt    <= r_s0_dt;
            r_s1_start <= r_s0_start;
            r_fprod    <= 32'(r_cfg.fade_rate) * 32'(r_s0_rdt);
            r_sprod    <= 32'(w_spin_mag) * 32'(r_s0_dt);
            r_s1_sneg  <= r_cfg.spin_rate[sas_pkg::MS_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide both products by 1000 (truncating, magnitudes)
    // ------------------------------------------------------------------
    logic [63:0]                 w_drop_full;
    logic [63:0]                 w_dang_full;
    sas_pkg::t_func              r_s2_func;
    logic [sas_pkg::MS_W-1:0]    r_s2_dt;
    logic [sas_pkg::START_W-1:0] r_s2_start;
    logic [sas_pkg::DIV_W-1:0]   r_drop;
    logic [sas_pkg::DIV_W-1:0]   r_dang;
    logic                        r_s2_sneg;

    assign w_drop_full = 64'(r_fprod) * 64'(sas_pkg::RECIP_1000);
    assign w_dang_full = 64'(r_sprod) * 64'(sas_pkg::RECIP_1000);

    always_ff @(posedge i_clk) begin
        if (en[2] && r_vld[1]) begin
            r_s2_func  <= r_s1_func;
            r_s2_dt    <= r_s1_dt;
            r_s2_start <= r_s1_start;
            r_drop     <= w_drop_full[sas_pkg::RECIP_1000_SH +: sas_pkg::DIV_W];
            r_dang     <= w_dang_full[sas_pkg::RECIP_1000_SH +: sas_pkg::DIV_W];
            r_s2_sneg  <= r_s1_sneg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: animation state. The state registers are the stage register:
    // they only change on reset or when a request enters this stage.
    // ------------------------------------------------------------------
    logic [FRAME_BITS-1:0]           r_frame,  n_frame;
    logic [sas_pkg::ACC_W-1:0]       r_accum,  n_accum;
    logic [sas_pkg::LEVEL_W-1:0]     r_vis,    n_vis;
    logic [sas_pkg::ANGLE_W-1:0]     r_angle,  n_angle;
    logic [sas_pkg::START_W-1:0]     r_start,  n_start;

    always_comb begin
        logic [sas_pkg::ACC_W:0]   acc_sum;
        logic [sas_pkg::ACC_W-1:0] acc_sat;
        logic [CW-1:0]             f;
        logic signed [VW-1:0]      nv;
        logic signed [VW-1:0]      delta;
        logic [sas_pkg::ANGLE_W:0] na;

        n_frame = r_frame;
        n_accum = r_accum;
        n_vis   = r_vis;
        n_angle = r_angle;
        n_start = r_start;

        acc_sum = {1'b0, r_accum} + 33'(r_s2_dt);
        acc_sat = acc_sum[sas_pkg::ACC_W] ? '1 : acc_sum[sas_pkg::ACC_W-1:0];
        f       = CW'(r_frame) + CW'(1);
        nv      = $signed({8'd0, r_vis}) - $signed({1'b0, r_drop});
        delta   = r_s2_sneg ? -$signed({1'b0, r_dang}) : $signed({1'b0, r_dang});
        na      = {r_angle[sas_pkg::ANGLE_W-1], r_angle}
                + {{(sas_pkg::ANGLE_W+1-VW){delta[VW-1]}}, delta};

        if (r_s2_func == sas_pkg::FUNC_START) begin
            // rewind
            n_frame = '0;
            n_accum = '0;
            n_vis   = r_cfg.fade_levels[31:16];
            n_start = r_s2_start;
            n_angle = {{(sas_pkg::ANGLE_W-sas_pkg::START_W){r_s2_start[sas_pkg::START_W-1]}},
                       r_s2_start};
        end else begin
            n_accum = acc_sat;

            // step the frame at most once per tick
            if ((acc_sat >= 32'(r_cfg.frame_period_ms)) && (r_cfg.frame_count != 8'd1)) begin
                n_accum = acc_sat - 32'(r_cfg.frame_period_ms);
                if (f >= CW'(r_cfg.frame_count)) begin
                    f = r_cfg.mode_flags[sas_pkg::MODE_FRAME_LOOP] ? '0 : (f - CW'(1));
                end
                n_frame = f[FRAME_BITS-1:0];
            end

            // fade: reload or drop to zero once at or below the end level
            if (r_cfg.mode_flags[sas_pkg::MODE_FADE_EN]) begin
                if (nv <= $signed({8'd0, r_cfg.fade_levels[sas_pkg::LEVEL_W-1:0]})) begin
                    n_vis = r_cfg.mode_flags[sas_pkg::MODE_FADE_LOOP]
                          ? r_cfg.fade_levels[31:16] : '0;
                end else begin
                    n_vis = nv[sas_pkg::LEVEL_W-1:0];
                end
            end

            // spin with saturation at the signed 32-bit limits
            if (r_cfg.mode_flags[sas_pkg::MODE_ROT_EN]) begin
                if (na[sas_pkg::ANGLE_W] != na[sas_pkg::ANGLE_W-1]) begin
                    n_angle = na[sas_pkg::ANGLE_W] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
                end else begin
                    n_angle = na[sas_pkg::ANGLE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_accum <= '0;
            r_vis   <= '0;
            r_angle <= '0;
            r_start <= '0;
        end else if (en[3] && r_vld[2]) begin
            r_frame <= n_frame;
            r_accum <= n_accum;
            r_vis   <= n_vis;
            r_angle <= n_angle;
            r_start <= n_start;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: whole turns since the start angle, and |angle| / 23040.
    // Turns always follow from angle and start, so they are not held as state.
    // ------------------------------------------------------------------
    logic [sas_pkg::ANGLE_W:0]   w_diff;
    logic                        w_tsat;
    logic [44:0]                 w_tprod;
    logic [sas_pkg::TURN_W-1:0]  w_turns;
    logic [sas_pkg::ANGLE_W-1:0] w_aabs;
    logic [46:0]                 w_mprod;
    sas_pkg::t_fin_in            r_s4;
    logic [FRAME_BITS-1:0]       r_s4_frame;
    logic [sas_pkg::ANGLE_W-1:0] r_s4_angle;

    assign w_diff  = {r_angle[sas_pkg::ANGLE_W-1], r_angle}
                   - {{(sas_pkg::ANGLE_W+1-sas_pkg::START_W){r_start[sas_pkg::START_W-1]}},
                      r_start};
    assign w_tsat  = (w_diff >= sas_pkg::TURN_CLAMP);
    assign w_tprod = 45'(w_diff[30:sas_pkg::TURN_SHIFT]) * 45'(sas_pkg::RECIP_45_T);

    always_comb begin
        if (w_diff[sas_pkg::ANGLE_W]) begin
            w_turns = '0;
        end else if (w_tsat) begin
            w_turns = '1;
        end else begin
            w_turns = w_tprod[sas_pkg::RECIP_45_T_SH +: sas_pkg::TURN_W];
        end
    end

    assign w_aabs  = r_angle[sas_pkg::ANGLE_W-1] ? (~r_angle + 32'd1) : r_angle;
    assign w_mprod = 47'(w_aabs[sas_pkg::ANGLE_W-1:sas_pkg::TURN_SHIFT])
                   * 47'(sas_pkg::RECIP_45_M);

    always_ff @(posedge i_clk) begin
        if (en[4] && r_vld[3]) begin
            r_s4.accum <= r_accum;
            r_s4.vis   <= r_vis;
            r_s4.turns <= w_turns;
            r_s4.aabs  <= w_aabs;
            r_s4.qm    <= w_mprod[sas_pkg::RECIP_45_M_SH +: sas_pkg::QM_W];
            r_s4_frame <= r_frame;
            r_s4_angle <= r_angle;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: finish test and result register
    // ------------------------------------------------------------------
    logic                            w_finished;
    logic [CW-1:0]                   w_frame_ext;
    logic [sas_pkg::FRAME_O_W-1:0]   r_out_frame;
    logic [sas_pkg::LEVEL_W-1:0]     r_out_vis;
    logic [sas_pkg::ANGLE_W-1:0]     r_out_angle;
    logic [sas_pkg::TURN_W-1:0]      r_out_turns;
    logic                            r_out_fin;

    sas_finish #(
        .FRAME_BITS (FRAME_BITS)
    ) u_finish (
        .i_cfg      (r_cfg),
        .i_frame    (r_s4_frame),
        .i_st       (r_s4),
        .o_finished (w_finished)
    );

    assign w_frame_ext = CW'(r_s4_frame);

    always_ff @(posedge i_clk) begin
        if (en[5] && r_vld[4]) begin
            r_out_frame <= w_frame_ext[sas_pkg::FRAME_O_W-1:0];
            r_out_vis   <= r_s4.vis;
            r_out_angle <= r_s4_angle;
            r_out_turns <= r_s4.turns;
            r_out_fin   <= w_finished;
        end
    end

    assign o_res.valid       = r_vld[NSTG-1];
    assign o_res.frame_index = r_out_frame;
    assign o_res.visibility  = r_out_vis;
    assign o_res.angle       = r_out_angle;
    assign o_res.turns       = r_out_turns;
    assign o_res.finished    = r_out_fin;

endmodule
